/* src/btli_pkg.sv */
package btli_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DATA_WIDTH = 64;
  localparam int IDX_W      = 24;
  localparam int DIM_W      = 13;
  localparam int POS_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int SB_W       = DATA_WIDTH + 1;
  localparam int DIV_N      = IDX_W;
  // start edge to strobe sample: input reg, two dividers, four merge stages
  localparam int BTLI_LAT   = 1 + 2 * DIV_N + 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_ROWS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_COLS   = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]      source_index;
    logic [DATA_WIDTH-1:0] element_in;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]      dest_index;
    logic [DATA_WIDTH-1:0] element_out;
    logic                  index_error;
  } out_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] th;
    logic [DIM_W-1:0] tw;
  } dims_t;

endpackage

/* src/btli_div.sv */
module btli_div
  import btli_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             v_i,
  input  logic [DIV_N-1:0] num_i,
  input  logic [DIM_W-1:0] dvs_i,
  input  logic [SB_W-1:0]  sb_i,
  output logic             v_o,
  output logic [DIV_N-1:0] quo_o,
  output logic [DIM_W-1:0] rem_o,
  output logic [SB_W-1:0]  sb_o
);

  // restoring division, one quotient bit per stage
  logic [DIV_N-1:0] v_r;
  logic [DIV_N-1:0] num_r   [DIV_N];
  logic [DIV_N-1:0] num_nxt [DIV_N];
  logic [DIM_W-1:0] rem_r   [DIV_N];
  logic [DIM_W-1:0] rem_nxt [DIV_N];
  logic [SB_W-1:0]  sb_r    [DIV_N];
  logic [SB_W-1:0]  sb_nxt  [DIV_N];

  always_comb begin
    logic [DIV_N-1:0] pn;
    logic [DIM_W-1:0] pr;
    logic [DIM_W:0]   trial;
    for (int k = 0; k < DIV_N; k++) begin
      if (k == 0) begin
        pn = num_i;
        pr = '0;
        sb_nxt[k] = sb_i;
      end else begin
        pn = num_r[k-1];
        pr = rem_r[k-1];
        sb_nxt[k] = sb_r[k-1];
      end
      trial = {pr, pn[DIV_N-1]};
      if (trial >= {1'b0, dvs_i}) begin
        rem_nxt[k] = DIM_W'(trial - {1'b0, dvs_i});
        num_nxt[k] = {pn[DIV_N-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[DIM_W-1:0];
        num_nxt[k] = {pn[DIV_N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[DIV_N-2:0], v_i};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_N; k++) begin
      num_r[k] <= num_nxt[k];
      rem_r[k] <= rem_nxt[k];
      sb_r[k]  <= sb_nxt[k];
    end
  end

  assign v_o   = v_r[DIV_N-1];
  assign quo_o = num_r[DIV_N-1];
  assign rem_o = rem_r[DIV_N-1];
  assign sb_o  = sb_r[DIV_N-1];

endmodule

/* src/btli_merge.sv */
module btli_merge
  import btli_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  v_i,
  input  dims_t                 dims_i,
  input  logic [POS_W-1:0]      br_i,
  input  logic [POS_W-1:0]      rr_i,
  input  logic [POS_W-1:0]      bc_i,
  input  logic [POS_W-1:0]      cc_i,
  input  logic [DATA_WIDTH-1:0] elem_i,
  input  logic                  err_i,
  output logic                  v_o,
  output out_t                  res_o
);

  logic [3:0] v_r;

  // stage A: block origins
  logic [2*DIM_W-2:0]    a_p1_r, a_p2_r;
  logic [POS_W-1:0]      a_rr_r, a_cc_r;
  logic [DATA_WIDTH-1:0] a_elem_r;
  logic                  a_err_r;
  // stage B: edge block sizes, block-row base
  logic [DIM_W-1:0]      b_h_r, b_w_r, b_p2_r;
  logic [2*DIM_W-1:0]    b_base_r;
  logic [POS_W-1:0]      b_rr_r, b_cc_r;
  logic [DATA_WIDTH-1:0] b_elem_r;
  logic                  b_err_r;
  // stage C: block offset, row offset inside block
  logic [2*DIM_W-1:0]    c_t2_r, c_base_r;
  logic [2*DIM_W-2:0]    c_t3_r;
  logic [POS_W-1:0]      c_cc_r;
  logic [DATA_WIDTH-1:0] c_elem_r;
  logic                  c_err_r;
  out_t                  res_r;

  logic [DIM_W-1:0]   h_left, w_left, h_nxt, w_nxt;
  logic [2*DIM_W+1:0] sum;

  always_comb begin
    h_left = dims_i.rows - a_p1_r[DIM_W-1:0];
    w_left = dims_i.cols - a_p2_r[DIM_W-1:0];
    h_nxt  = (dims_i.th < h_left) ? dims_i.th : h_left;
    w_nxt  = (dims_i.tw < w_left) ? dims_i.tw : w_left;
    sum    = (2*DIM_W+2)'(c_base_r) + (2*DIM_W+2)'(c_t2_r)
           + (2*DIM_W+2)'(c_t3_r) + (2*DIM_W+2)'(c_cc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], v_i};
    end
  end

  always_ff @(posedge clk) begin
    a_p1_r   <= br_i * dims_i.th;
    a_p2_r   <= bc_i * dims_i.tw;
    a_rr_r   <= rr_i;
    a_cc_r   <= cc_i;
    a_elem_r <= elem_i;
    a_err_r  <= err_i;

    b_h_r    <= h_nxt;
    b_w_r    <= w_nxt;
    b_p2_r   <= a_p2_r[DIM_W-1:0];
    b_base_r <= a_p1_r[DIM_W-1:0] * dims_i.cols;
    b_rr_r   <= a_rr_r;
    b_cc_r   <= a_cc_r;
    b_elem_r <= a_elem_r;
    b_err_r  <= a_err_r;

    c_t2_r   <= b_p2_r * b_h_r;
    c_t3_r   <= b_rr_r * b_w_r;
    c_base_r <= b_base_r;
    c_cc_r   <= b_cc_r;
    c_elem_r <= b_elem_r;
    c_err_r  <= b_err_r;

    res_r.dest_index  <= c_err_r ? '0 : sum[IDX_W-1:0];
    res_r.element_out <= c_elem_r;
    res_r.index_error <= c_err_r;
  end

  assign v_o   = v_r[3];
  assign res_o = res_r;

endmodule

/* src/block_tiled_layout_index.sv */
// Channel  | Ports                          | Transaction
// ---------+--------------------------------+-----------------------------------
// input    | start, busy, in_data           | start high and busy low at clk edge
// result   | out_valid, out_data            | out_valid high for one cycle
// config   | cfg_we, cfg_index, cfg_wdata   | cfg_we high at clk edge
//
// One element enters per cycle; busy is tied low. From its start edge, each
// result passes through 1 input stage, two 24-stage bit-per-stage dividers
// for row/col and block row/col, and 4 multiply/merge stages.
// Reset (rst_n low, synchronous) clears all valid bits and sets every
// dimension register to 1. The receiver cannot stall; results are strobed.
module block_tiled_layout_index
  import btli_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  output logic                 out_valid,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  // zero reads as one, anything above MAX_DIM saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  dims_t dims_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.rows <= DIM_W'(1);
      dims_r.cols <= DIM_W'(1);
      dims_r.th   <= DIM_W'(1);
      dims_r.tw   <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MATRIX_ROWS: dims_r.rows <= clamp_dim(cfg_wdata);
        CFG_MATRIX_COLS: dims_r.cols <= clamp_dim(cfg_wdata);
        CFG_TILE_ROWS:   dims_r.th   <= clamp_dim(cfg_wdata);
        CFG_TILE_COLS:   dims_r.tw   <= clamp_dim(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input stage: capture transaction, range check against rows*cols
  logic                  s1_v_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic [DATA_WIDTH-1:0] s1_elem_r;
  logic [2*DIM_W-1:0]    limit;
  logic                  s1_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= in_data.source_index;
    s1_elem_r <= in_data.element_in;
  end

  assign limit  = dims_r.rows * dims_r.cols;
  assign s1_err = (2*DIM_W)'(s1_idx_r) >= limit;

  // idx -> (row, col)
  logic             d1_v;
  logic [DIV_N-1:0] d1_quo;
  logic [DIM_W-1:0] d1_rem;
  logic [SB_W-1:0]  d1_sb;

  btli_div u_div_rc (
    .clk   (clk),
    .rst_n (rst_n),
    .v_i   (s1_v_r),
    .num_i (s1_idx_r),
    .dvs_i (dims_r.cols),
    .sb_i  ({s1_err, s1_elem_r}),
    .v_o   (d1_v),
    .quo_o (d1_quo),
    .rem_o (d1_rem),
    .sb_o  (d1_sb)
  );

  // row -> (block row, row in block); col -> (block col, col in block)
  logic             d2_v;
  logic [DIV_N-1:0] d2r_quo, d2c_quo;
  logic [DIM_W-1:0] d2r_rem, d2c_rem;
  logic [SB_W-1:0]  d2_sb;

  btli_div u_div_row (
    .clk   (clk),
    .rst_n (rst_n),
    .v_i   (d1_v),
    .num_i (d1_quo),
    .dvs_i (dims_r.th),
    .sb_i  (d1_sb),
    .v_o   (d2_v),
    .quo_o (d2r_quo),
    .rem_o (d2r_rem),
    .sb_o  (d2_sb)
  );

  btli_div u_div_col (
    .clk   (clk),
    .rst_n (rst_n),
    .v_i   (d1_v),
    .num_i (DIV_N'(d1_rem)),
    .dvs_i (dims_r.tw),
    .sb_i  ('0),
    .v_o   (),
    .quo_o (d2c_quo),
    .rem_o (d2c_rem),
    .sb_o  ()
  );

  // index arithmetic; out-of-range garbage is masked at the last stage
  btli_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .v_i    (d2_v),
    .dims_i (dims_r),
    .br_i   (d2r_quo[POS_W-1:0]),
    .rr_i   (d2r_rem[POS_W-1:0]),
    .bc_i   (d2c_quo[POS_W-1:0]),
    .cc_i   (d2c_rem[POS_W-1:0]),
    .elem_i (d2_sb[DATA_WIDTH-1:0]),
    .err_i  (d2_sb[DATA_WIDTH]),
    .v_o    (out_valid),
    .res_o  (out_data)
  );

endmodule

/* src/btli_checker.sv */
module btli_checker
  import btli_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy asserted");

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, BTLI_LAT))
    else $error("result without matching transaction");

  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.element_out == $past(in_data.element_in, BTLI_LAT))
    else $error("data word corrupted");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_error |-> out_data.dest_index == '0)
    else $error("nonzero dest on index error");

endmodule

bind block_tiled_layout_index btli_checker u_btli_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
